### hdl/sdm_pkg.sv
`default_nettype none
package sdm_pkg;

    // Store geometry
    localparam int unsigned MAX_PIXELS = 131072;
    localparam int unsigned IDX_W      = $clog2(MAX_PIXELS);

    // Field widths
    localparam int unsigned LEVEL_W = 8;
    localparam int unsigned AMP_W   = 4;
    localparam int unsigned PROD_W  = LEVEL_W + AMP_W;
    localparam int unsigned ENTRY_W = 2 * LEVEL_W;

    localparam logic [LEVEL_W-1:0] MAX_LEVEL = '1;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [AMP_W-1:0]   amp_t;
    typedef logic [PROD_W-1:0]  prod_t;

    // Register select codes (byte address bit 2)
    typedef enum logic {
        REG_AMPLIFICATION    = 1'b0,
        REG_INITIAL_VARIANCE = 1'b1
    } reg_sel_t;

    // Stage 1: accepted pixel, store read in flight
    typedef struct packed {
        logic   valid;
        idx_t   idx;
        level_t pixel;
        logic   init;
    } s1_t;

    // Stage 2: background done, variance pending
    typedef struct packed {
        logic   valid;
        idx_t   idx;
        logic   init;
        level_t background;
        level_t difference;
        prod_t  target;
        level_t variance_rd;
    } s2_t;

    // Stage 3: finished result
    typedef struct packed {
        logic   valid;
        idx_t   idx;
        level_t background;
        level_t difference;
        level_t variance;
        logic   motion;
    } s3_t;

    // Newer copy of a store entry held in the pipeline
    typedef struct packed {
        logic   valid;
        idx_t   idx;
        level_t background;
        level_t variance;
    } fwd_t;

    // Move value one unit toward target, saturating at the top level
    function automatic level_t step_toward(input level_t value, input prod_t target);
        prod_t value_ext;
        value_ext = prod_t'(value);
        if (value_ext < target) begin
            step_toward = (value == MAX_LEVEL) ? MAX_LEVEL : value + level_t'(1);
        end else if (value_ext > target) begin
            step_toward = value - level_t'(1);
        end else begin
            step_toward = value;
        end
    endfunction

endpackage
`default_nettype wire

### hdl/sdm_pixel_mem.sv
`default_nettype none
module sdm_pixel_mem (
    input  wire logic                        aclk,
    input  wire logic                        rd_en,
    input  wire sdm_pkg::idx_t               rd_addr,
    input  wire logic                        wr_en,
    input  wire sdm_pkg::idx_t               wr_addr,
    input  wire logic [sdm_pkg::ENTRY_W-1:0] wr_data,
    output logic [sdm_pkg::ENTRY_W-1:0]      rd_data
);
    import sdm_pkg::*;

    // Background in the upper byte, variance in the lower byte
    logic [ENTRY_W-1:0] mem [MAX_PIXELS];
    logic [ENTRY_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds while stalled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### hdl/sdm_bg_update.sv
`default_nettype none
module sdm_bg_update (
    input  wire sdm_pkg::s1_t    s1,
    input  wire sdm_pkg::level_t bg_rd,
    input  wire sdm_pkg::level_t var_rd,
    input  wire sdm_pkg::fwd_t   fwd_near,
    input  wire sdm_pkg::fwd_t   fwd_far,
    input  wire sdm_pkg::amp_t   amplification,
    output sdm_pkg::s2_t         s2_next
);
    import sdm_pkg::*;

    level_t old_bg;
    level_t diff;

    // Pick the newest background for this index
    always_comb begin
        if (fwd_near.valid && fwd_near.idx == s1.idx) begin
            old_bg = fwd_near.background;
        end else if (fwd_far.valid && fwd_far.idx == s1.idx) begin
            old_bg = fwd_far.background;
        end else begin
            old_bg = bg_rd;
        end
    end

    assign diff = (old_bg >= s1.pixel) ? old_bg - s1.pixel : s1.pixel - old_bg;

    // Step background (or load it from the pixel on init), form difference and variance target
    always_comb begin
        s2_next.valid       = s1.valid;
        s2_next.idx         = s1.idx;
        s2_next.init        = s1.init;
        s2_next.variance_rd = var_rd;
        if (s1.init) begin
            s2_next.background = s1.pixel;
            s2_next.difference = '0;
            s2_next.target     = '0;
        end else begin
            s2_next.background = step_toward(old_bg, prod_t'(s1.pixel));
            s2_next.difference = diff;
            s2_next.target     = prod_t'(diff) * prod_t'(amplification);
        end
    end

endmodule
`default_nettype wire

### hdl/sdm_var_update.sv
`default_nettype none
module sdm_var_update (
    input  wire sdm_pkg::s2_t    s2,
    input  wire sdm_pkg::fwd_t   fwd_near,
    input  wire sdm_pkg::fwd_t   fwd_far,
    input  wire sdm_pkg::level_t initial_variance,
    output sdm_pkg::s3_t         s3_next
);
    import sdm_pkg::*;

    level_t old_var;
    level_t new_var;

    // Pick the newest variance for this index
    always_comb begin
        if (fwd_near.valid && fwd_near.idx == s2.idx) begin
            old_var = fwd_near.variance;
        end else if (fwd_far.valid && fwd_far.idx == s2.idx) begin
            old_var = fwd_far.variance;
        end else begin
            old_var = s2.variance_rd;
        end
    end

    assign new_var = s2.init ? initial_variance : step_toward(old_var, s2.target);

    // Assemble the result; init pixels never flag motion
    always_comb begin
        s3_next.valid      = s2.valid;
        s3_next.idx        = s2.idx;
        s3_next.background = s2.background;
        s3_next.difference = s2.difference;
        s3_next.variance   = new_var;
        s3_next.motion     = !s2.init && !(s2.difference < new_var);
    end

endmodule
`default_nettype wire

### hdl/sigma_delta_motion_pixel_core.sv
// Each input transaction passes through the stage 1, stage 2 and stage 3 registers; the stage 3
// register holds the result. Throughput: one pixel per cycle unless the output stalls; the
// background/variance store is read on accept and written as each pixel leaves stage 2, with
// newer entries forwarded from the pipeline registers.
// Reset: clears stage valid bits and loads amplification 4, initial variance 2.
// The pixel store is not cleared; an entry reads as unknown until an init pixel writes it.
`default_nettype none
module sigma_delta_motion_pixel_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [7:0] pixel, [24:8] pixel_index, [31:25] zero
    input  wire logic        s_tuser,   // [0] init_frame
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] background, [15:8] difference,
                                        // [23:16] variance
    output logic             m_tuser,   // [0] motion
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import sdm_pkg::*;

    amp_t     amplification_reg;
    level_t   initial_variance_reg;
    reg_sel_t reg_sel;
    logic     cfg_write;

    s1_t  s1_reg;
    s2_t  s2_reg;
    s3_t  s3_reg;
    fwd_t hist_reg;

    s1_t  s1_next;
    s2_t  s2_next;
    s3_t  s3_next;
    fwd_t fwd_s2;
    fwd_t fwd_s3;
    logic advance;

    logic [ENTRY_W-1:0] rd_data;

    // Configuration registers
    assign pready    = 1'b1;
    assign reg_sel   = reg_sel_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amplification_reg    <= amp_t'(4);
            initial_variance_reg <= level_t'(2);
        end else if (cfg_write) begin
            case (reg_sel)
                REG_AMPLIFICATION:    amplification_reg    <= pwdata[AMP_W-1:0];
                REG_INITIAL_VARIANCE: initial_variance_reg <= pwdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_AMPLIFICATION:    prdata = 32'(amplification_reg);
            REG_INITIAL_VARIANCE: prdata = 32'(initial_variance_reg);
            default:              prdata = '0;
        endcase
    end

    // Advance the whole pipeline unless the output register is stalled
    assign advance  = !s3_reg.valid || m_tready;
    assign s_tready = advance;

    assign s1_next.valid = s_tvalid;
    assign s1_next.idx   = s_tdata[8 +: IDX_W];
    assign s1_next.pixel = s_tdata[7:0];
    assign s1_next.init  = s_tuser;

    // Store read on accept, write as each pixel leaves stage 2
    sdm_pixel_mem u_mem (
        .aclk    (aclk),
        .rd_en   (advance),
        .rd_addr (s1_next.idx),
        .wr_en   (advance && s2_reg.valid),
        .wr_addr (s2_reg.idx),
        .wr_data ({s3_next.background, s3_next.variance}),
        .rd_data (rd_data)
    );

    // Forwarding sources; stage 2 has no variance yet and bg forwarding ignores it
    assign fwd_s2.valid      = s2_reg.valid;
    assign fwd_s2.idx        = s2_reg.idx;
    assign fwd_s2.background = s2_reg.background;
    assign fwd_s2.variance   = '0;

    assign fwd_s3.valid      = s3_reg.valid;
    assign fwd_s3.idx        = s3_reg.idx;
    assign fwd_s3.background = s3_reg.background;
    assign fwd_s3.variance   = s3_reg.variance;

    sdm_bg_update u_bg (
        .s1            (s1_reg),
        .bg_rd         (rd_data[ENTRY_W-1:LEVEL_W]),
        .var_rd        (rd_data[LEVEL_W-1:0]),
        .fwd_near      (fwd_s2),
        .fwd_far       (fwd_s3),
        .amplification (amplification_reg),
        .s2_next       (s2_next)
    );

    sdm_var_update u_var (
        .s2               (s2_reg),
        .fwd_near         (fwd_s3),
        .fwd_far          (hist_reg),
        .initial_variance (initial_variance_reg),
        .s3_next          (s3_next)
    );

    // Pipeline registers; only valid bits are reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid   <= 1'b0;
            s2_reg.valid   <= 1'b0;
            s3_reg.valid   <= 1'b0;
            hist_reg.valid <= 1'b0;
        end else if (advance) begin
            s1_reg   <= s1_next;
            s2_reg   <= s2_next;
            s3_reg   <= s3_next;
            hist_reg <= fwd_s3;
        end
    end

    assign m_tvalid = s3_reg.valid;
    assign m_tdata  = {s3_reg.variance, s3_reg.difference, s3_reg.background};
    assign m_tuser  = s3_reg.motion;

endmodule
`default_nettype wire

### tb/sv/sigma_delta_motion_pixel_core_tb.sv
`default_nettype none
module sigma_delta_motion_pixel_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sdm_pkg::*;

    localparam int unsigned PIPE_LATENCY  = 3;
    localparam int unsigned ITEMS_PER_SET = 200;
    localparam int unsigned SETTING_COUNT = 6;
    localparam int unsigned SHOW_LIMIT    = 100;

    typedef struct packed {
        idx_t   idx;
        level_t background;
        level_t difference;
        level_t variance;
        logic   motion;
    } pixel_result_t;

    // Background/variance tracker and result checker
    class motion_scoreboard;
        level_t        bg_mem  [MAX_PIXELS];
        level_t        var_mem [MAX_PIXELS];
        amp_t          amp;
        level_t        init_var;
        pixel_result_t awaiting[$];
        int            errors;
        int            results;

        function new();
            amp      = amp_t'(4);
            init_var = level_t'(2);
            errors   = 0;
            results  = 0;
        endfunction

        // Move one unit toward target, holding at the top level
        function automatic level_t nudge(level_t value, int unsigned target);
            if (int'(value) < target) begin
                return (value == MAX_LEVEL) ? MAX_LEVEL : value + level_t'(1);
            end else if (int'(value) > target) begin
                return value - level_t'(1);
            end
            return value;
        endfunction

        function void set_reg(reg_sel_t sel, logic [31:0] value);
            if (sel == REG_AMPLIFICATION) begin
                amp = value[AMP_W-1:0];
            end else begin
                init_var = value[LEVEL_W-1:0];
            end
        endfunction

        function logic [31:0] reg_value(reg_sel_t sel);
            if (sel == REG_AMPLIFICATION) begin
                return 32'(amp);
            end
            return 32'(init_var);
        endfunction

        // Update the pixel model for an accepted transaction and queue its result
        function void note_pixel(level_t pix, idx_t idx, logic init);
            pixel_result_t exp_res;
            level_t        old_bg;
            exp_res.idx = idx;
            if (init) begin
                exp_res.background = pix;
                exp_res.difference = '0;
                exp_res.variance   = init_var;
                exp_res.motion     = 1'b0;
            end else begin
                old_bg             = bg_mem[idx];
                exp_res.background = nudge(old_bg, int'(pix));
                exp_res.difference = (old_bg >= pix) ? old_bg - pix : pix - old_bg;
                exp_res.variance   = nudge(var_mem[idx],
                                           int'(exp_res.difference) * int'(amp));
                exp_res.motion     = (exp_res.difference >= exp_res.variance);
            end
            bg_mem[idx]  = exp_res.background;
            var_mem[idx] = exp_res.variance;
            awaiting.push_back(exp_res);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= SHOW_LIMIT) begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
        endtask

        // Compare one result transaction with the oldest expectation
        task check_result(logic [23:0] data, logic motion);
            pixel_result_t exp_res;
            results++;
            if (awaiting.size() == 0) begin
                report_mismatch($sformatf("unexpected result data=%h motion=%b", data, motion));
            end else begin
                exp_res = awaiting.pop_front();
                if (data[7:0] !== exp_res.background || data[15:8] !== exp_res.difference ||
                    data[23:16] !== exp_res.variance || motion !== exp_res.motion) begin
                    report_mismatch($sformatf(
                        "idx %0d bg %h/%h diff %h/%h var %h/%h motion %b/%b (got/exp)",
                        exp_res.idx, data[7:0], exp_res.background, data[15:8],
                        exp_res.difference, data[23:16], exp_res.variance, motion,
                        exp_res.motion));
                end
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [7:0] pixel, [24:8] pixel_index, [31:25] zero
    logic        s_tuser;   // [0] init_frame
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [7:0] background, [15:8] difference, [23:16] variance
    logic        m_tuser;   // [0] motion
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    motion_scoreboard sb = new();

    bit          seeded [MAX_PIXELS];
    idx_t        hot_idx [16];
    idx_t        last_idx;
    bit          quiet;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int          sent;
    int          settings_used;

    sigma_delta_motion_pixel_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Hard stop on a hung run
    initial begin
        #400000;
        $display("FAIL");
        $finish;
    end

    // Check every accepted result transaction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tuser);
        end
    end

    // Drive m_tready with random stall bursts
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (!quiet && $urandom_range(99) < recv_idle_pct) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end
            m_tready = 1'b1;
            @(negedge aclk);
        end
    end

    // Offer one pixel transaction, optionally after an idle burst, and hold until accepted
    task automatic send_pixel(level_t pix, idx_t idx, logic init);
        @(negedge aclk);
        if (!quiet && $urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {7'd0, idx, pix};
        s_tuser  = init;
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel(pix, idx, init);
        if (init) begin
            seeded[idx] = 1'b1;
        end
        last_idx = idx;
        sent++;
    endtask

    // Drop the input stream and wait until every expected result is out
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.awaiting.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 2) @(posedge aclk);
    endtask

    task automatic apb_write(reg_sel_t sel, logic [31:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {sel, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(sel, value);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_check(reg_sel_t sel);
        logic [31:0] got;
        @(negedge aclk);
        psel    = 1'b1;
        pwrite  = 1'b0;
        penable = 1'b0;
        paddr   = {sel, 2'b00};
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        if (got !== sb.reg_value(sel)) begin
            sb.report_mismatch($sformatf("register %s read %h expected %h",
                                         sel.name(), got, sb.reg_value(sel)));
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Load a register setting while the pipeline is empty
    task automatic configure(amp_t amp, level_t init_var);
        wait_drained();
        apb_write(REG_AMPLIFICATION, 32'(amp));
        apb_write(REG_INITIAL_VARIANCE, 32'(init_var));
        apb_check(REG_AMPLIFICATION);
        apb_check(REG_INITIAL_VARIANCE);
        settings_used++;
    endtask

    // Random pixel: index from a hot set, a repeat or anywhere; init forced on fresh entries
    task automatic send_random_pixel();
        int unsigned roll;
        idx_t        idx;
        level_t      bg;
        level_t      pix;
        int          near;
        logic        init;
        roll = $urandom_range(99);
        if (roll < 15) begin
            idx = idx_t'($urandom_range(MAX_PIXELS - 1));
        end else if (roll < 35) begin
            idx = last_idx;
        end else begin
            idx = hot_idx[$urandom_range(15)];
        end
        init = !seeded[idx] || ($urandom_range(99) < 6);
        // Fresh entries have no background yet; pick any level around which to aim
        bg   = seeded[idx] ? sb.bg_mem[idx] : level_t'($urandom_range(255));
        roll = $urandom_range(99);
        if (roll < 25) begin
            pix = level_t'($urandom_range(255));
        end else if (roll < 55) begin
            near = int'(bg) + $urandom_range(6) - 3;
            pix  = (near < 0) ? 8'd0 : (near > 255) ? 8'd255 : level_t'(near);
        end else if (roll < 70) begin
            pix = $urandom_range(1) ? 8'd255 : 8'd0;
        end else if (roll < 85) begin
            pix = bg;
        end else begin
            pix = bg ^ 8'h80;
        end
        send_pixel(pix, idx, init);
    endtask

    initial begin
        amp_t   amp_set [SETTING_COUNT];
        level_t var_set [SETTING_COUNT];

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        quiet    = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        sent          = 0;
        settings_used = 0;
        last_idx      = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings: index and pixel extremes, back-to-back hits on one entry
        apb_check(REG_AMPLIFICATION);
        apb_check(REG_INITIAL_VARIANCE);
        send_pixel(8'd0,   17'd0,       1'b1);
        send_pixel(8'd255, 17'h1FFFF,   1'b1);
        send_pixel(8'd255, 17'd0,       1'b0);
        send_pixel(8'd0,   17'h1FFFF,   1'b0);
        send_pixel(8'd255, 17'd0,       1'b0);
        send_pixel(8'd255, 17'd0,       1'b0);
        send_pixel(8'hAA,  17'h0AAAA,   1'b1);
        send_pixel(8'h55,  17'h15555,   1'b1);
        send_pixel(8'hAA,  17'h0AAAA,   1'b0);
        send_pixel(8'h55,  17'h15555,   1'b0);
        send_pixel(8'h55,  17'h0AAAA,   1'b0);
        send_pixel(8'd1,   17'h1FFFF,   1'b0);

        // Top amplification and variance: target far above the saturation level
        configure(amp_t'(15), 8'd255);
        send_pixel(8'd128, 17'd5,     1'b1);
        send_pixel(8'd0,   17'd5,     1'b0);
        send_pixel(8'd255, 17'd5,     1'b0);
        send_pixel(8'd7,   17'h1FFFF, 1'b1);

        // Zero amplification and zero initial variance: variance only falls
        configure(amp_t'(0), 8'd0);
        send_pixel(8'd200, 17'd5, 1'b0);
        send_pixel(8'd0,   17'd5, 1'b0);
        send_pixel(8'd9,   17'd6, 1'b1);
        send_pixel(8'd9,   17'd6, 1'b0);
        send_pixel(8'd40,  17'd6, 1'b0);

        amp_set = '{amp_t'(4), amp_t'(15), amp_t'(0), amp_t'(1), amp_t'(15),
                    amp_t'($urandom_range(1, 15))};
        var_set = '{8'd2, 8'd255, 8'd0, 8'd0, 8'd0, level_t'($urandom_range(255))};

        // Random phases, one per register setting; the last one runs without idling
        for (int s = 0; s < SETTING_COUNT; s++) begin
            configure(amp_set[s], var_set[s]);
            hot_idx[0] = 17'd0;
            hot_idx[1] = 17'h1FFFF;
            for (int h = 2; h < 16; h++) begin
                hot_idx[h] = idx_t'($urandom_range(MAX_PIXELS - 1));
            end
            quiet = (s == SETTING_COUNT - 1);
            for (int n = 0; n < ITEMS_PER_SET; n++) begin
                if (n % 50 == 0) begin
                    send_idle_pct = 20 * $urandom_range(2);
                    recv_idle_pct = 20 * $urandom_range(2);
                end
                // Let the pipeline empty once in the middle of a phase
                if (s == 1 && n == ITEMS_PER_SET / 2) begin
                    wait_drained();
                end
                send_random_pixel();
            end
        end

        wait_drained();
        if (sb.awaiting.size() != 0) begin
            sb.report_mismatch($sformatf("%0d results never arrived", sb.awaiting.size()));
        end
        $display("Run covered %0d pixel transactions and %0d results over %0d register settings,",
                 sent, sb.results, settings_used + 1);
        $display("including zero and top amplification, variance saturation and entry reuse.");
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
